### rtl/core/timing_wheel_timer_pool_unit_assert.svh
// Assertion macros for the timing wheel timer pool checker.
// Depends on nothing; include once per asserting file.
`ifndef TIMING_WHEEL_TIMER_POOL_UNIT_ASSERT_SVH
`define TIMING_WHEEL_TIMER_POOL_UNIT_ASSERT_SVH

// Same-cycle implication, skipped while reset is high
`define TWTP_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("twtp check failed");

// Next-cycle implication, skipped while reset is high
`define TWTP_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("twtp check failed");

`endif

### rtl/core/twtp_pkg.sv
// Shared types and constants of the timing wheel timer pool.
// Depends on nothing; used by the engine, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package twtp_pkg;

   // Wheel geometry; slots and tick unit are powers of two
   localparam int SLOTS      = 64;
   localparam int TICK_UNIT  = 1;
   localparam int TIMERS     = 64;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int TICK_SHIFT = $clog2(TICK_UNIT);
   localparam int IDX_W      = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int ROT_W      = 32 - SLOT_W;
   localparam int HANDLE_W   = 6;

   // Action codes
   localparam logic [1:0] ACTION_ADD    = 2'd0;
   localparam logic [1:0] ACTION_DELETE = 2'd1;
   localparam logic [1:0] ACTION_TICK   = 2'd2;

   // Status codes
   localparam logic [2:0] STATUS_ADDED    = 3'd0;
   localparam logic [2:0] STATUS_NEGATIVE = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_DELETED  = 3'd3;
   localparam logic [2:0] STATUS_BAD      = 3'd4;
   localparam logic [2:0] STATUS_EXPIRED  = 3'd5;
   localparam logic [2:0] STATUS_NONE     = 3'd6;

   typedef struct packed {
      logic [1:0]          action;
      logic signed [31:0]  timeout;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [HANDLE_W-1:0] result_handle;
      logic                last;
   } rsp_type;

   // One pool entry as held in the entry memory
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [ROT_W-1:0]  rotation;
   } entry_type;

   // Engine to entry memory access
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

### rtl/core/twtp_entry_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing; holds the slot and rotation of each pool entry.
`timescale 1ns / 1ps
`default_nettype none

module twtp_entry_ram #(
   parameter int ADDR_W = 6,
   parameter int WIDTH  = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write the addressed word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/twtp_engine.sv
// Control engine of the timing wheel: valid bits, wheel pointer, scans.
// Depends on twtp_pkg; drives the entry memory through ram_req_type.
`timescale 1ns / 1ps
`default_nettype none

module twtp_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire twtp_pkg::req_type     req_data,
   output logic                       rsp_valid,
   output twtp_pkg::rsp_type          rsp_data,
   output twtp_pkg::ram_req_type      ram_req,
   input  wire twtp_pkg::entry_type   ram_rd_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ADD   = 2'd1;
   localparam logic [1:0] ST_TICK  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   localparam logic [twtp_pkg::IDX_W-1:0] IDX_LAST =
      twtp_pkg::IDX_W'(twtp_pkg::TIMERS - 1);

   logic [1:0]                        state_ff, state_in;
   logic [twtp_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [twtp_pkg::TIMERS-1:0]       valid_ff, valid_in;
   logic [twtp_pkg::SLOT_W-1:0]       cur_ff, cur_in;
   logic                              pend_ff, pend_in;
   logic [twtp_pkg::IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   twtp_pkg::entry_type               add_entry_ff, add_entry_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   twtp_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                              accept;
   logic [31:0]                       ticks;
   logic [31:0]                       ticks_min;
   logic                              bad_handle;
   logic [twtp_pkg::IDX_W-1:0]        del_idx;
   logic                              hit;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Convert the timeout to ticks, at least one
   assign ticks     = {1'b0, req_data.timeout[30:0]} >> twtp_pkg::TICK_SHIFT;
   assign ticks_min = (ticks == 32'd0) ? 32'd1 : ticks;

   // Check the delete handle against the pool
   assign del_idx    = req_data.handle[twtp_pkg::IDX_W-1:0];
   assign bad_handle = ((twtp_pkg::HANDLE_W + 1)'(req_data.handle)
                        >= (twtp_pkg::HANDLE_W + 1)'(twtp_pkg::TIMERS))
                       || !valid_ff[del_idx];

   // Entry under scan waits in the current slot
   assign hit = valid_ff[idx_ff] && (ram_rd_data.slot == cur_ff);

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      valid_in         = valid_ff;
      cur_in           = cur_ff;
      pend_in          = pend_ff;
      pend_idx_in      = pend_idx_ff;
      add_entry_in     = add_entry_ff;
      rsp_valid_in     = 1'b0;
      rsp_in           = '0;
      ram_req          = '0;
      ram_req.rd_addr  = idx_ff + twtp_pkg::IDX_W'(1);
      ram_req.wr_addr  = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  twtp_pkg::ACTION_ADD: begin
                     if (req_data.timeout[31]) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = twtp_pkg::STATUS_NEGATIVE;
                        rsp_in.last   = 1'b1;
                     end else begin
                        add_entry_in.slot     = cur_ff + ticks_min[twtp_pkg::SLOT_W-1:0];
                        add_entry_in.rotation =
                           ticks_min[twtp_pkg::SLOT_W +: twtp_pkg::ROT_W];
                        idx_in   = '0;
                        state_in = ST_ADD;
                     end
                  end
                  twtp_pkg::ACTION_DELETE: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                     if (bad_handle) begin
                        rsp_in.status = twtp_pkg::STATUS_BAD;
                     end else begin
                        valid_in[del_idx]    = 1'b0;
                        rsp_in.status        = twtp_pkg::STATUS_DELETED;
                        rsp_in.result_handle = req_data.handle;
                     end
                  end
                  twtp_pkg::ACTION_TICK: begin
                     ram_req.rd_addr = '0;
                     idx_in          = '0;
                     pend_in         = 1'b0;
                     state_in        = ST_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Walk the valid bits for the lowest free entry
         ST_ADD: begin
            if (!valid_ff[idx_ff]) begin
               ram_req.wr_en        = 1'b1;
               ram_req.wr_data      = add_entry_ff;
               valid_in[idx_ff]     = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.status        = twtp_pkg::STATUS_ADDED;
               rsp_in.result_handle = twtp_pkg::HANDLE_W'(idx_ff);
               rsp_in.last          = 1'b1;
               state_in             = ST_IDLE;
            end else if (idx_ff == IDX_LAST) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = twtp_pkg::STATUS_FULL;
               rsp_in.last   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in = idx_ff + twtp_pkg::IDX_W'(1);
            end
         end

         // Count down or expire one entry per cycle; hold one expiry back
         ST_TICK: begin
            if (hit) begin
               if (ram_rd_data.rotation != '0) begin
                  ram_req.wr_en            = 1'b1;
                  ram_req.wr_data.slot     = ram_rd_data.slot;
                  ram_req.wr_data.rotation = ram_rd_data.rotation - twtp_pkg::ROT_W'(1);
               end else begin
                  valid_in[idx_ff] = 1'b0;
                  if (pend_ff) begin
                     rsp_valid_in         = 1'b1;
                     rsp_in.status        = twtp_pkg::STATUS_EXPIRED;
                     rsp_in.result_handle = twtp_pkg::HANDLE_W'(pend_idx_ff);
                  end
                  pend_in     = 1'b1;
                  pend_idx_in = idx_ff;
               end
            end
            if (idx_ff == IDX_LAST) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in = idx_ff + twtp_pkg::IDX_W'(1);
            end
         end

         // Close the tick and advance the wheel
         ST_FLUSH: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            if (pend_ff) begin
               rsp_in.status        = twtp_pkg::STATUS_EXPIRED;
               rsp_in.result_handle = twtp_pkg::HANDLE_W'(pend_idx_ff);
            end else begin
               rsp_in.status = twtp_pkg::STATUS_NONE;
            end
            pend_in  = 1'b0;
            cur_in   = cur_ff + twtp_pkg::SLOT_W'(1);
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         valid_ff     <= '0;
         cur_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      add_entry_ff <= add_entry_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### rtl/core/timing_wheel_timer_pool_unit.sv
// Top level of the hashed timing wheel over a pool of 64 timers.
// Depends on twtp_pkg, twtp_engine and twtp_entry_ram.
//
// Usage:
//   Commands enter on req_data and are taken at a clock edge where start is
//   high and busy is low. Actions: add a timer, delete a timer by handle,
//   advance the wheel one tick. Action code 3 is taken and dropped.
//   Results leave on rsp_data, each marked by rsp_valid for one cycle; the
//   last result of a command carries last = 1. The receiver cannot stall.
// Command handling:
//   Delete and a rejected add answer in the cycle after the command.
//   Add walks the valid bits for the lowest free entry, one per cycle,
//   and is busy for the walk.
//   Tick streams every pool entry through the entry memory once, one per
//   cycle, plus a closing step, busy throughout; expiries come out during
//   the scan one entry behind, the final one (or a none status) after it.
// Reset:
//   Synchronous reset empties the pool (valid bits cleared) and sets the
//   wheel to slot 0. The entry memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module timing_wheel_timer_pool_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire twtp_pkg::req_type  req_data,
   output logic                    rsp_valid,
   output twtp_pkg::rsp_type       rsp_data
);

   twtp_pkg::ram_req_type ram_req;
   twtp_pkg::entry_type   ram_rd_data;

   // Sequence commands and scans
   twtp_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   // Hold slot and rotation of each entry
   twtp_entry_ram #(
      .ADDR_W (twtp_pkg::IDX_W),
      .WIDTH  ($bits(twtp_pkg::entry_type))
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

### rtl/core/twtp_checker.sv
// Port-level checks of the timing wheel timer pool, bound to the top level.
// Depends on twtp_pkg and timing_wheel_timer_pool_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "timing_wheel_timer_pool_unit_assert.svh"

module twtp_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire twtp_pkg::req_type  req_data,
   input  wire logic               rsp_valid,
   input  wire twtp_pkg::rsp_type  rsp_data
);

   logic accept;
   logic single_status;
   logic no_handle_status;
   logic zero_handle;
   logic del_accept;
   logic del_answer;
   logic tick_accept;

   assign accept = start && !busy;

   // Every status but an expiry closes its transaction
   assign single_status = rsp_data.status != twtp_pkg::STATUS_EXPIRED;

   // Failures and an empty tick carry no handle
   assign no_handle_status = (rsp_data.status == twtp_pkg::STATUS_NEGATIVE)
                          || (rsp_data.status == twtp_pkg::STATUS_FULL)
                          || (rsp_data.status == twtp_pkg::STATUS_BAD)
                          || (rsp_data.status == twtp_pkg::STATUS_NONE);
   assign zero_handle = rsp_data.result_handle == '0;

   // Delete answers right away; tick starts a scan with no answer yet
   assign del_accept  = accept && (req_data.action == twtp_pkg::ACTION_DELETE);
   assign del_answer  = rsp_valid && ((rsp_data.status == twtp_pkg::STATUS_DELETED)
                                   || (rsp_data.status == twtp_pkg::STATUS_BAD));
   assign tick_accept = accept && (req_data.action == twtp_pkg::ACTION_TICK);

   `TWTP_ASSERT_NOW(a_single_last, clock, reset, rsp_valid && single_status, rsp_data.last)
   `TWTP_ASSERT_NOW(a_zero_handle, clock, reset, rsp_valid && no_handle_status, zero_handle)
   `TWTP_ASSERT_NEXT(a_delete_answer, clock, reset, del_accept, del_answer)
   `TWTP_ASSERT_NEXT(a_tick_busy, clock, reset, tick_accept, busy && !rsp_valid)

endmodule

bind timing_wheel_timer_pool_unit twtp_checker u_twtp_checker (.*);

`default_nettype wire
